FILE: sv/lscs_pkg.sv
// Shared constants, types and state encodings of the line segment cell selector.
`default_nettype none

package lscs_pkg;

  // Width of a coordinate, signed Q16.16 at its nominal value.
  localparam int COORD_WIDTH = 32;
  localparam int INV_WIDTH   = 48;
  localparam int CFG_WIDTH   = (COORD_WIDTH > INV_WIDTH) ? COORD_WIDTH : INV_WIDTH;
  localparam int CFG_INDEX_W = 3;

  // Difference of two coordinates, product of two differences, its magnitude.
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int MAG_W  = 2 * DIFF_W;

  // Operand halves of the partial-product multipliers in the back end.
  localparam int HALF_A = MAG_W / 2;
  localparam int HALF_B = INV_WIDTH / 2;
  localparam int PP_W   = HALF_A + HALF_B;
  localparam int PROD_W = MAG_W + INV_WIDTH;

  // Result scaling: both products carry a 2^-72 scale, outputs keep 16 fraction bits.
  localparam int FRAC_SHIFT = 56;
  localparam int ONE_T_BIT  = 72;
  localparam int SAT_BIT    = 88;
  localparam int ACC_W      = (PROD_W > SAT_BIT + 1) ? PROD_W : SAT_BIT + 1;

  localparam int INDEX_W = 32;
  localparam int POS_W   = ONE_T_BIT - FRAC_SHIFT + 1;
  localparam int DIST_W  = SAT_BIT - FRAC_SHIFT;

  localparam logic [ACC_W-1:0] ONE_T = {{(ACC_W-1){1'b0}}, 1'b1} << ONE_T_BIT;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_START_X   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_END_X     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_END_Y     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_LEN_SQ = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_LEN   = 3'd5;

  // Item kinds.
  localparam logic FUNC_VERTEX   = 1'b0;
  localparam logic FUNC_CENTROID = 1'b1;

  // Candidate queue between front and back end; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [MAG_W-1:0]   dot_mag;
    logic [MAG_W-1:0]   cross_mag;
  } cand_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_P0,
    FR_P1,
    FR_CROSS,
    FR_P3,
    FR_DOT,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC,
    BK_FINISH
  } back_state_t;

endpackage

`default_nettype wire

FILE: sv/lscs_front.sv
// Front end: accepts items, forms the cross and dot products, tracks cell sides.
`default_nettype none

module lscs_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  func,
  input  wire logic signed [lscs_pkg::COORD_WIDTH-1:0] coord_x,
  input  wire logic signed [lscs_pkg::COORD_WIDTH-1:0] coord_y,
  input  wire logic signed [lscs_pkg::COORD_WIDTH-1:0] start_x,
  input  wire logic signed [lscs_pkg::COORD_WIDTH-1:0] start_y,
  input  wire logic signed [lscs_pkg::COORD_WIDTH-1:0] end_x,
  input  wire logic signed [lscs_pkg::COORD_WIDTH-1:0] end_y,
  input  wire logic [lscs_pkg::INV_WIDTH-1:0]        inv_length_squared,
  input  wire logic [lscs_pkg::INV_WIDTH-1:0]        inv_length,
  output logic                                       push_valid,
  output lscs_pkg::cand_t                            push_data,
  input  wire lscs_pkg::queue_status_t               q_status
);

  localparam int CW    = lscs_pkg::COORD_WIDTH;
  localparam int DW    = lscs_pkg::DIFF_W;
  localparam int MW    = lscs_pkg::MAG_W;

  lscs_pkg::front_state_t state, state_next;

  logic signed [DW-1:0] abx, aby, dx, dy;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] mul_p, pa, pb;
  logic [MW:0]          cross_w, dot_w, cross_abs, dot_abs;
  logic                 func_r;
  logic                 seen_nonnegative, seen_negative;
  logic [lscs_pkg::INDEX_W-1:0] cell_counter;
  logic [MW-1:0]        cross_mag;
  logic                 vertex_neg, cand_ok;
  logic                 use_dx, use_abx;

  // Segment direction, refreshed every cycle from the configuration registers.
  always_ff @(posedge clk) begin
    abx <= $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
    aby <= $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
  end

  assign mul_a = use_dx ? dx : dy;
  assign mul_b = use_abx ? abx : aby;
  assign mul_p = mul_a * mul_b;

  assign cross_w   = {pa[MW-1], pa} - {pb[MW-1], pb};
  assign dot_w     = {pa[MW-1], pa} + {pb[MW-1], pb};
  assign cross_abs = cross_w[MW] ? (~cross_w + 1'b1) : cross_w;
  assign dot_abs   = dot_w[MW] ? (~dot_w + 1'b1) : dot_w;

  // A vertex lies below the line only when the scaled distance is nonzero.
  assign vertex_neg = cross_w[MW] && (inv_length != '0);
  // A negative projection rules the cell out before any long multiplication.
  assign cand_ok = seen_nonnegative && seen_negative &&
                   !(dot_w[MW] && (inv_length_squared != '0));

  always_comb begin
    state_next = state;
    case (state)
      lscs_pkg::FR_IDLE:  if (in_valid) state_next = lscs_pkg::FR_P0;
      lscs_pkg::FR_P0:    state_next = lscs_pkg::FR_P1;
      lscs_pkg::FR_P1:    state_next = lscs_pkg::FR_CROSS;
      lscs_pkg::FR_CROSS: begin
        state_next = (func_r == lscs_pkg::FUNC_CENTROID) ? lscs_pkg::FR_P3 : lscs_pkg::FR_IDLE;
      end
      lscs_pkg::FR_P3:    state_next = lscs_pkg::FR_DOT;
      lscs_pkg::FR_DOT:   state_next = cand_ok ? lscs_pkg::FR_PUSH : lscs_pkg::FR_IDLE;
      lscs_pkg::FR_PUSH:  if (!q_status.full) state_next = lscs_pkg::FR_IDLE;
      default:            state_next = lscs_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    push_valid = 1'b0;
    use_dx     = 1'b1;
    use_abx    = 1'b0;
    case (state)
      lscs_pkg::FR_IDLE:  in_stall = 1'b0;
      lscs_pkg::FR_P0:    begin use_dx = 1'b1; use_abx = 1'b0; end
      lscs_pkg::FR_P1:    begin use_dx = 1'b0; use_abx = 1'b1; end
      lscs_pkg::FR_CROSS: begin use_dx = 1'b1; use_abx = 1'b1; end
      lscs_pkg::FR_P3:    begin use_dx = 1'b0; use_abx = 1'b0; end
      lscs_pkg::FR_DOT:   ;
      lscs_pkg::FR_PUSH:  push_valid = 1'b1;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= lscs_pkg::FR_IDLE;
      seen_nonnegative <= 1'b0;
      seen_negative    <= 1'b0;
      cell_counter     <= '0;
    end else begin
      state <= state_next;
      if (state == lscs_pkg::FR_CROSS && func_r == lscs_pkg::FUNC_VERTEX) begin
        if (vertex_neg) seen_negative <= 1'b1;
        else            seen_nonnegative <= 1'b1;
      end
      if (state == lscs_pkg::FR_DOT) begin
        seen_nonnegative <= 1'b0;
        seen_negative    <= 1'b0;
        cell_counter     <= cell_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lscs_pkg::FR_IDLE && in_valid) begin
      dx     <= $signed({coord_x[CW-1], coord_x}) - $signed({start_x[CW-1], start_x});
      dy     <= $signed({coord_y[CW-1], coord_y}) - $signed({start_y[CW-1], start_y});
      func_r <= func;
    end
    case (state)
      lscs_pkg::FR_P0:    pa <= mul_p;
      lscs_pkg::FR_P1:    pb <= mul_p;
      lscs_pkg::FR_CROSS: begin
        pa        <= mul_p;
        cross_mag <= cross_abs[MW-1:0];
      end
      lscs_pkg::FR_P3:    pb <= mul_p;
      lscs_pkg::FR_DOT:   begin
        push_data.idx       <= cell_counter;
        push_data.dot_mag   <= dot_abs[MW-1:0];
        push_data.cross_mag <= cross_mag;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/lscs_queue.sv
// Short register queue that carries candidate cells from front to back end.
`default_nettype none

module lscs_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire lscs_pkg::cand_t         push_data,
  input  wire logic                    pop,
  output lscs_pkg::cand_t              pop_data,
  output lscs_pkg::queue_status_t      status
);

  lscs_pkg::cand_t entries [lscs_pkg::QUEUE_DEPTH];

  logic [lscs_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [lscs_pkg::QPTR_W:0]   count;
  logic                        do_push, do_pop;

  assign status.full  = (count == (lscs_pkg::QPTR_W + 1)'(lscs_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/lscs_back.sv
// Back end: scales candidates by the inverse lengths, range-checks t, drives results.
`default_nettype none

module lscs_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  output logic                                 pop,
  input  wire lscs_pkg::cand_t                 pop_data,
  input  wire lscs_pkg::queue_status_t         q_status,
  input  wire logic [lscs_pkg::INV_WIDTH-1:0]  inv_length_squared,
  input  wire logic [lscs_pkg::INV_WIDTH-1:0]  inv_length,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [lscs_pkg::INDEX_W-1:0]         cell_index,
  output logic [lscs_pkg::POS_W-1:0]           position_on_line,
  output logic [lscs_pkg::DIST_W-1:0]          distance_to_line
);

  localparam int MW = lscs_pkg::MAG_W;
  localparam int HA = lscs_pkg::HALF_A;
  localparam int HB = lscs_pkg::HALF_B;
  localparam int AW = lscs_pkg::ACC_W;

  lscs_pkg::back_state_t state, state_next;

  logic [MW-1:0]                dmag, cmag;
  logic [lscs_pkg::INDEX_W-1:0] idx;
  logic [1:0]                   step, pp_code;
  logic [lscs_pkg::PP_W-1:0]    pp_t, pp_d;
  logic [AW-1:0]                acc_t, acc_d;
  logic [HA-1:0]                a_t, a_d;
  logic [HB-1:0]                b_t, b_d;
  logic                         acc_en, selected, out_free, load, sat;

  function automatic logic [AW-1:0] place(input logic [lscs_pkg::PP_W-1:0] pp,
                                          input logic [1:0] code);
    logic [AW-1:0] ext;
    ext = {{(AW - lscs_pkg::PP_W){1'b0}}, pp};
    case (code)
      2'd0:    place = ext;
      2'd1:    place = ext << HA;
      2'd2:    place = ext << HB;
      2'd3:    place = ext << (HA + HB);
      default: place = ext;
    endcase
  endfunction

  // Step bit 0 picks the magnitude half, step bit 1 the inverse-length half.
  assign a_t = step[0] ? dmag[MW-1:HA] : dmag[HA-1:0];
  assign a_d = step[0] ? cmag[MW-1:HA] : cmag[HA-1:0];
  assign b_t = step[1] ? inv_length_squared[2*HB-1:HB] : inv_length_squared[HB-1:0];
  assign b_d = step[1] ? inv_length[2*HB-1:HB] : inv_length[HB-1:0];

  assign selected = (acc_t <= lscs_pkg::ONE_T);
  assign out_free = !out_valid || !out_stall;
  assign sat      = |acc_d[AW-1:lscs_pkg::SAT_BIT];

  always_comb begin
    state_next = state;
    case (state)
      lscs_pkg::BK_IDLE:   if (!q_status.empty) state_next = lscs_pkg::BK_MUL;
      lscs_pkg::BK_MUL:    if (step == 2'd3) state_next = lscs_pkg::BK_ACC;
      lscs_pkg::BK_ACC:    state_next = lscs_pkg::BK_FINISH;
      lscs_pkg::BK_FINISH: if (!selected || out_free) state_next = lscs_pkg::BK_IDLE;
      default:             state_next = lscs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    acc_en = 1'b0;
    load   = 1'b0;
    case (state)
      lscs_pkg::BK_IDLE:   pop = !q_status.empty;
      lscs_pkg::BK_MUL:    acc_en = (step != 2'd0);
      lscs_pkg::BK_ACC:    acc_en = 1'b1;
      lscs_pkg::BK_FINISH: load = selected && out_free;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lscs_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load)           out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dmag  <= pop_data.dot_mag;
      cmag  <= pop_data.cross_mag;
      idx   <= pop_data.idx;
      step  <= 2'd0;
      acc_t <= '0;
      acc_d <= '0;
    end
    if (state == lscs_pkg::BK_MUL) begin
      pp_t    <= a_t * b_t;
      pp_d    <= a_d * b_d;
      pp_code <= step;
      step    <= step + 1'b1;
    end
    if (acc_en) begin
      acc_t <= acc_t + place(pp_t, pp_code);
      acc_d <= acc_d + place(pp_d, pp_code);
    end
    if (load) begin
      cell_index       <= idx;
      position_on_line <= acc_t[lscs_pkg::ONE_T_BIT:lscs_pkg::FRAC_SHIFT];
      distance_to_line <= sat ? '1 : acc_d[lscs_pkg::SAT_BIT-1:lscs_pkg::FRAC_SHIFT];
    end
  end

endmodule

`default_nettype wire

FILE: sv/line_segment_cell_selector_core.sv
// Top level of the line segment cell selector: configuration registers and wiring.
//
// Software writes the segment end points and the two inverse lengths through the
// plain write port (cfg_write, cfg_index, cfg_data) while the block is idle.
// Cells then stream in on the input channel, one vertex per transaction, each
// cell closed by a centroid transaction (func high). A transaction is taken when
// in_valid is high and in_stall is low. A selected cell produces one transaction
// on the output channel carrying its running index, t and the centroid distance.
// The front end takes no new transaction until it is done with the last: a vertex
// passes states P0, P1 and CROSS, a centroid also P3 and DOT, and PUSH when the
// cell is a candidate; all products share the single 33x33 multiplier of the front
// end. The back end works on one candidate at a time through MUL, ACC and FINISH
// with its partial-product multipliers, and a two-entry queue lets both ends run
// apart. Reset clears both flags, the cell counter, the queue and the config
// registers. When the receiver holds out_stall, the result stays on the outputs
// and the back end waits; the front end keeps working until the queue fills.
`default_nettype none

module line_segment_cell_selector_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write,
  input  wire logic [lscs_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [lscs_pkg::CFG_WIDTH-1:0]          cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic                                    func,
  input  wire logic signed [lscs_pkg::COORD_WIDTH-1:0] coord_x,
  input  wire logic signed [lscs_pkg::COORD_WIDTH-1:0] coord_y,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [lscs_pkg::INDEX_W-1:0]                 cell_index,
  output logic [lscs_pkg::POS_W-1:0]                   position_on_line,
  output logic [lscs_pkg::DIST_W-1:0]                  distance_to_line
);

  localparam int CW = lscs_pkg::COORD_WIDTH;
  localparam int IW = lscs_pkg::INV_WIDTH;

  logic signed [CW-1:0] start_x, start_y, end_x, end_y;
  logic [IW-1:0]        inv_length_squared, inv_length;

  logic                    push_valid, pop;
  lscs_pkg::cand_t         push_data, pop_data;
  lscs_pkg::queue_status_t q_status;

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x            <= '0;
      start_y            <= '0;
      end_x              <= '0;
      end_y              <= '0;
      inv_length_squared <= '0;
      inv_length         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lscs_pkg::REG_START_X:    start_x            <= cfg_data[CW-1:0];
        lscs_pkg::REG_START_Y:    start_y            <= cfg_data[CW-1:0];
        lscs_pkg::REG_END_X:      end_x              <= cfg_data[CW-1:0];
        lscs_pkg::REG_END_Y:      end_y              <= cfg_data[CW-1:0];
        lscs_pkg::REG_INV_LEN_SQ: inv_length_squared <= cfg_data[IW-1:0];
        lscs_pkg::REG_INV_LEN:    inv_length         <= cfg_data[IW-1:0];
        default:                  ;
      endcase
    end
  end

  // The front end classifies vertices and forms exact cross and dot products.
  lscs_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .coord_x            (coord_x),
    .coord_y            (coord_y),
    .start_x            (start_x),
    .start_y            (start_y),
    .end_x              (end_x),
    .end_y              (end_y),
    .inv_length_squared (inv_length_squared),
    .inv_length         (inv_length),
    .push_valid         (push_valid),
    .push_data          (push_data),
    .q_status           (q_status)
  );

  // Only cells with vertices on both sides and a usable sign of t are queued.
  lscs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // The back end applies the inverse lengths and owns the output register.
  lscs_back u_back (
    .clk                (clk),
    .rst                (rst),
    .pop                (pop),
    .pop_data           (pop_data),
    .q_status           (q_status),
    .inv_length_squared (inv_length_squared),
    .inv_length         (inv_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .cell_index         (cell_index),
    .position_on_line   (position_on_line),
    .distance_to_line   (distance_to_line)
  );

endmodule

`default_nettype wire

FILE: sv/lscs_checker.sv
// Port-level checks of the line segment cell selector, bound to its top level.
`default_nettype none

module lscs_checker (
  input wire logic                                    clk,
  input wire logic                                    rst,
  input wire logic                                    in_valid,
  input wire logic                                    in_stall,
  input wire logic                                    out_valid,
  input wire logic                                    out_stall,
  input wire logic [lscs_pkg::INDEX_W-1:0]            cell_index,
  input wire logic [lscs_pkg::POS_W-1:0]              position_on_line,
  input wire logic [lscs_pkg::DIST_W-1:0]             distance_to_line
);

  localparam logic [lscs_pkg::POS_W-1:0] T_ONE = 17'h10000;

  // Reset leaves the block ready for input with no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // Each item keeps the front end busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken right after the first");

  // A stalled result holds its payload.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_index) &&
    $stable(position_on_line) && $stable(distance_to_line))
    else $error("stalled result changed");

  // A selected cell always lies within the segment's span.
  a_t_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position_on_line <= T_ONE)
    else $error("position_on_line above one");

endmodule

bind line_segment_cell_selector_core lscs_checker u_lscs_checker (.*);

`default_nettype wire
